>>> rtl/midi_track_event_parser_unit_macros.svh
// assertion macros used by the checker file
// each macro needs clk and rst_n in scope at the point of use
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH

// same-cycle implication, skipped during reset
`define MTEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("midi track parser check failed");

// next-cycle implication, skipped during reset
`define MTEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("midi track parser check failed");

`endif

>>> rtl/mtep_pkg.sv
// types and constants for the midi track event parser
// no dependencies; used by the parser unit and its checker
package mtep_pkg;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_TEMPO   = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } byte_word_t;

    typedef struct packed {
        kind_t       event_kind;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [23:0] tempo_value;
        logic [31:0] delta_ticks;
        logic [31:0] total_ticks;
    } event_word_t;

    localparam logic [7:0] STATUS_MIN     = 8'h80;
    localparam logic [7:0] META_STATUS    = 8'hFF;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [3:0] GROUP_PROGRAM  = 4'hC;
    localparam logic [3:0] GROUP_PRESSURE = 4'hD;
    localparam logic [3:0] GROUP_SYSTEM   = 4'hF;
    localparam logic [7:0] TEMPO_BYTES    = 8'd3;

endpackage

>>> rtl/mtep_varlen.sv
// variable-length delta time accumulation for the midi track parser
// combinational; no package dependency
module mtep_varlen (
    input  logic [7:0]  data_byte,
    input  logic [31:0] varlen_value,
    input  logic [31:0] delta_sum,
    output logic [31:0] varlen_next,
    output logic [31:0] delta_next,
    output logic        last_byte
);

    logic [31:0] shifted;

    // seven payload bits per byte, msb group first, value wraps at 32 bits
    assign shifted     = {varlen_value[24:0], data_byte[6:0]};
    assign last_byte   = ~data_byte[7];
    assign varlen_next = last_byte ? 32'd0 : shifted;
    assign delta_next  = last_byte ? (delta_sum + shifted) : delta_sum;

endmodule

>>> rtl/midi_track_event_parser_unit.sv
// Parses type 0 midi track bytes, one byte per cycle while the input is not stalled, into
// channel, tempo and end-of-track events with delta and running tick totals. A result
// appears in the output register on the cycle after the byte that completes its event.
// The input stalls only while a result sits in the output register with its consumer stalled.
module midi_track_event_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  mtep_pkg::byte_word_t byte_word,
    output logic                 event_valid,
    input  logic                 event_stall,
    output mtep_pkg::event_word_t event_word
);

    typedef enum logic [2:0] {
        PH_DELTA   = 3'd0,
        PH_STATUS  = 3'd1,
        PH_FIRST   = 3'd2,
        PH_SECOND  = 3'd3,
        PH_METALEN = 3'd4,
        PH_TEMPO   = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] varlen_reg, varlen_next;
    logic [31:0] delta_sum_reg, delta_sum_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  skip_reg, skip_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [31:0] tick_reg, tick_next;
    logic        out_valid_reg;
    mtep_pkg::event_word_t out_word_reg, out_word_next;

    // state as seen by this byte, after an optional track restart
    phase_t      cur_phase;
    logic [31:0] cur_varlen;
    logic [31:0] cur_delta;
    logic [7:0]  cur_running;
    logic [7:0]  cur_status;
    logic [7:0]  cur_held;
    logic [7:0]  cur_skip;
    logic [23:0] cur_tempo;
    logic [31:0] cur_tick;

    logic [31:0] vl_varlen;
    logic [31:0] vl_delta;
    logic        vl_last;
    logic        emit;
    logic        accept;
    logic [7:0]  b;

    assign b      = byte_word.data_byte;
    assign accept = byte_valid & ~byte_stall;

    always_comb
    begin
        if (byte_word.track_start)
        begin
            cur_phase   = PH_DELTA;
            cur_varlen  = '0;
            cur_delta   = '0;
            cur_running = '0;
            cur_status  = '0;
            cur_held    = '0;
            cur_skip    = '0;
            cur_tempo   = '0;
            cur_tick    = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_varlen  = varlen_reg;
            cur_delta   = delta_sum_reg;
            cur_running = running_reg;
            cur_status  = status_reg;
            cur_held    = held_reg;
            cur_skip    = skip_reg;
            cur_tempo   = tempo_reg;
            cur_tick    = tick_reg;
        end
    end

    mtep_varlen u_varlen (
        .data_byte    (b),
        .varlen_value (cur_varlen),
        .delta_sum    (cur_delta),
        .varlen_next  (vl_varlen),
        .delta_next   (vl_delta),
        .last_byte    (vl_last)
    );

    always_comb
    begin
        logic [7:0] ds;
        logic [7:0] dd;
        logic       dispatch;
        logic [7:0] skip_dec;

        phase_next     = cur_phase;
        varlen_next    = cur_varlen;
        delta_sum_next = cur_delta;
        running_next   = cur_running;
        status_next    = cur_status;
        held_next      = cur_held;
        skip_next      = cur_skip;
        tempo_next     = cur_tempo;
        tick_next      = cur_tick;
        emit           = 1'b0;
        dispatch       = 1'b0;
        ds             = cur_status;
        dd             = cur_held;
        skip_dec       = cur_skip - 8'd1;

        out_word_next             = '0;
        out_word_next.event_kind  = mtep_pkg::KIND_CHANNEL;
        out_word_next.status_byte = cur_status;
        out_word_next.first_data  = cur_held;

        unique case (cur_phase)
            PH_STATUS:
            begin
                if (b >= mtep_pkg::STATUS_MIN)
                begin
                    status_next  = b;
                    running_next = b;
                    phase_next   = PH_FIRST;
                end
                else
                begin
                    // running status reuse: this byte is already the first data byte
                    ds          = cur_running;
                    dd          = b;
                    status_next = cur_running;
                    held_next   = b;
                    dispatch    = 1'b1;
                end
            end
            PH_FIRST:
            begin
                dd        = b;
                held_next = b;
                dispatch  = 1'b1;
            end
            PH_SECOND:
            begin
                emit                      = 1'b1;
                out_word_next.second_data = b;
            end
            PH_METALEN:
            begin
                if (cur_held == mtep_pkg::META_TEMPO)
                begin
                    tempo_next = '0;
                    skip_next  = mtep_pkg::TEMPO_BYTES;
                    phase_next = PH_TEMPO;
                end
                else if (cur_held == mtep_pkg::META_END)
                begin
                    emit                     = 1'b1;
                    out_word_next.event_kind = mtep_pkg::KIND_END;
                end
                else
                begin
                    skip_next  = b;
                    phase_next = (b == 8'd0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_TEMPO:
            begin
                tempo_next = {cur_tempo[15:0], b};
                skip_next  = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    emit                      = 1'b1;
                    out_word_next.event_kind  = mtep_pkg::KIND_TEMPO;
                    out_word_next.tempo_value = {cur_tempo[15:0], b};
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    phase_next = PH_DELTA;
                end
            end
            default:
            begin
                varlen_next    = vl_varlen;
                delta_sum_next = vl_delta;
                phase_next     = vl_last ? PH_STATUS : PH_DELTA;
            end
        endcase

        if (dispatch)
        begin
            out_word_next.status_byte = ds;
            out_word_next.first_data  = dd;
            if ((ds[7:4] == mtep_pkg::GROUP_PROGRAM) || (ds[7:4] == mtep_pkg::GROUP_PRESSURE))
            begin
                emit = 1'b1;
            end
            else if (ds[7:4] == mtep_pkg::GROUP_SYSTEM)
            begin
                if (ds == mtep_pkg::META_STATUS)
                begin
                    phase_next = PH_METALEN;
                end
                else
                begin
                    skip_next  = dd;
                    phase_next = (dd == 8'd0) ? PH_DELTA : PH_SKIP;
                end
            end
            else
            begin
                phase_next = PH_SECOND;
            end
        end

        if (emit)
        begin
            tick_next                 = cur_tick + cur_delta;
            delta_sum_next            = '0;
            phase_next                = PH_DELTA;
            out_word_next.delta_ticks = cur_delta;
            out_word_next.total_ticks = cur_tick + cur_delta;
        end
    end

    // input waits only while a finished word is held by the consumer
    assign byte_stall  = out_valid_reg & event_stall;
    assign event_valid = out_valid_reg;
    assign event_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DELTA;
            varlen_reg    <= '0;
            delta_sum_reg <= '0;
            running_reg   <= '0;
            status_reg    <= '0;
            held_reg      <= '0;
            skip_reg      <= '0;
            tempo_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                varlen_reg    <= varlen_next;
                delta_sum_reg <= delta_sum_next;
                running_reg   <= running_next;
                status_reg    <= status_next;
                held_reg      <= held_next;
                skip_reg      <= skip_next;
                tempo_reg     <= tempo_next;
                tick_reg      <= tick_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!event_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

>>> rtl/mtep_checker.sv
// port-level checks for the midi track event parser, bound to the top level
// depends on mtep_pkg and midi_track_event_parser_unit_macros.svh
`include "midi_track_event_parser_unit_macros.svh"

module mtep_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_stall,
    input logic                  event_valid,
    input logic                  event_stall,
    input mtep_pkg::event_word_t event_word
);

    logic is_end;
    logic is_tempo;
    logic end_fields_ok;
    logic tempo_fields_ok;

    assign is_end   = event_valid && (event_word.event_kind == mtep_pkg::KIND_END);
    assign is_tempo = event_valid && (event_word.event_kind == mtep_pkg::KIND_TEMPO);

    assign end_fields_ok = (event_word.status_byte == mtep_pkg::META_STATUS) &&
                           (event_word.first_data == mtep_pkg::META_END) &&
                           (event_word.tempo_value == 24'd0);

    assign tempo_fields_ok = (event_word.status_byte == mtep_pkg::META_STATUS) &&
                             (event_word.first_data == mtep_pkg::META_TEMPO) &&
                             (event_word.second_data == 8'd0);

    // a held word stays put until taken
    `MTEP_ASSERT_NEXT(a_hold_word, event_valid && event_stall, event_valid && $stable(event_word))

    // the parser never takes a byte while a word is stuck at its output
    `MTEP_ASSERT_NOW(a_stall_back, event_valid && event_stall, byte_stall)

    // end of track comes only from the ff 2f meta event
    `MTEP_ASSERT_NOW(a_end_meta, is_end, end_fields_ok)

    // tempo events come only from the ff 51 meta event
    `MTEP_ASSERT_NOW(a_tempo_meta, is_tempo, tempo_fields_ok)

endmodule

bind midi_track_event_parser_unit mtep_checker u_mtep_checker (.*);
